// ===== hw/rtl/voxel_face_cull_mesher_defines.svh =====
// Assertion helpers for the voxel mesher.
`ifndef VOXEL_FACE_CULL_MESHER_DEFINES_SVH
`define VOXEL_FACE_CULL_MESHER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define VFC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vfc assertion failed");

// Next-cycle implication, checked outside reset.
`define VFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vfc assertion failed");

`endif

// ===== hw/rtl/vfc_pkg.sv =====
`default_nettype none
package vfc_pkg;

  localparam int COUNT_W = 18;
  localparam int COORD_W = 18;
  localparam int INDEX_W = 20;
  localparam int NUM_FACES = 6;

  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_EMIT    = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] CFG_ORIGIN_Z = 2'd2;

  localparam logic [2:0] FACE_PZ = 3'd0;
  localparam logic [2:0] FACE_PX = 3'd1;
  localparam logic [2:0] FACE_NX = 3'd2;
  localparam logic [2:0] FACE_NZ = 3'd3;
  localparam logic [2:0] FACE_PY = 3'd4;
  localparam logic [2:0] FACE_NY = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CENTER,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [2:0]         face;
    logic [1:0]         corner;
    logic               last;
    logic [INDEX_W-1:0] index_base;
  } vtx_cmd_t;

  // Corner offset signs {x, y, z}: 1 for +1, 0 for -1.
  function automatic logic [2:0] corner_sign(input logic [2:0] face,
                                             input logic [1:0] corner);
    logic [2:0] s;
    s = 3'b000;
    case ({face, corner})
      {FACE_PZ, 2'd0}: s = 3'b111;
      {FACE_PZ, 2'd1}: s = 3'b101;
      {FACE_PZ, 2'd2}: s = 3'b001;
      {FACE_PZ, 2'd3}: s = 3'b011;
      {FACE_PX, 2'd0}: s = 3'b110;
      {FACE_PX, 2'd1}: s = 3'b100;
      {FACE_PX, 2'd2}: s = 3'b101;
      {FACE_PX, 2'd3}: s = 3'b111;
      {FACE_NX, 2'd0}: s = 3'b011;
      {FACE_NX, 2'd1}: s = 3'b001;
      {FACE_NX, 2'd2}: s = 3'b000;
      {FACE_NX, 2'd3}: s = 3'b010;
      {FACE_NZ, 2'd0}: s = 3'b010;
      {FACE_NZ, 2'd1}: s = 3'b000;
      {FACE_NZ, 2'd2}: s = 3'b100;
      {FACE_NZ, 2'd3}: s = 3'b110;
      {FACE_PY, 2'd0}: s = 3'b110;
      {FACE_PY, 2'd1}: s = 3'b111;
      {FACE_PY, 2'd2}: s = 3'b011;
      {FACE_PY, 2'd3}: s = 3'b010;
      {FACE_NY, 2'd0}: s = 3'b101;
      {FACE_NY, 2'd1}: s = 3'b100;
      {FACE_NY, 2'd2}: s = 3'b000;
      {FACE_NY, 2'd3}: s = 3'b001;
      default:         s = 3'b000;
    endcase
    return s;
  endfunction

  // Lowest set face in the exposure mask.
  function automatic logic [2:0] first_face(input logic [NUM_FACES-1:0] m);
    logic [2:0] f;
    f = 3'd0;
    for (int i = NUM_FACES - 1; i >= 0; i--) begin
      if (m[i]) begin
        f = 3'(i);
      end
    end
    return f;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/vfc_occ_ram.sv =====
`default_nettype none
module vfc_occ_ram #(
  parameter int DEPTH = 4096,
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata,
  output logic          clearing
);

  logic          mem [DEPTH];
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 1'b0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/vfc_vtx_gen.sv =====
`default_nettype none
module vfc_vtx_gen (
  input  logic                                clk,
  input  logic                                rst,
  input  vfc_pkg::vtx_cmd_t                   cmd,
  input  logic signed [vfc_pkg::COORD_W-1:0]  base_x,
  input  logic signed [vfc_pkg::COORD_W-1:0]  base_y,
  input  logic signed [vfc_pkg::COORD_W-1:0]  base_z,
  output logic                                strobe,
  output logic signed [vfc_pkg::COORD_W-1:0]  vert_x,
  output logic signed [vfc_pkg::COORD_W-1:0]  vert_y,
  output logic signed [vfc_pkg::COORD_W-1:0]  vert_z,
  output logic [2:0]                          face_dir,
  output logic [1:0]                          corner,
  output logic [vfc_pkg::INDEX_W-1:0]         index_base,
  output logic                                last
);

  import vfc_pkg::*;

  logic [2:0]                sgn;
  logic signed [COORD_W-1:0] dx, dy, dz;

  assign sgn = corner_sign(cmd.face, cmd.corner);
  assign dx  = sgn[2] ? COORD_W'(1) : -COORD_W'(1);
  assign dy  = sgn[1] ? COORD_W'(1) : -COORD_W'(1);
  assign dz  = sgn[0] ? COORD_W'(1) : -COORD_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    vert_x     <= base_x + dx;
    vert_y     <= base_y + dy;
    vert_z     <= base_z + dz;
    face_dir   <= cmd.face;
    corner     <= cmd.corner;
    index_base <= cmd.index_base;
    last       <= cmd.last;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/voxel_face_cull_mesher.sv =====
// Channel   Signals                                        Handshake
// request   req_type voxel_x voxel_y voxel_z occupied       start && !busy
// config    cfg_addr cfg_wdata                             cfg_we
// vertex    vert_x vert_y vert_z face_dir corner            strobe, one cycle
//           index_base last
//
// Write, restart and ignored requests leave busy low.
// An emit of an occupied voxel holds busy through one occupancy read for the
// voxel, six neighbour reads through the single read port, then four vertices
// per exposed face, one vertex per cycle from the shared vertex adder.
// An emit of an empty voxel holds busy only for its occupancy read.
// After reset busy stays high while the occupancy memory is swept to zero,
// one entry per cycle through its write port.
// Vertices leave one per cycle with no backpressure.
`default_nettype none
`include "voxel_face_cull_mesher_defines.svh"
module voxel_face_cull_mesher #(
  parameter int GRID_EDGE = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          req_type,
  input  logic [5:0]                          voxel_x,
  input  logic [5:0]                          voxel_y,
  input  logic [5:0]                          voxel_z,
  input  logic                                occupied,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_addr,
  input  logic [15:0]                         cfg_wdata,
  output logic                                strobe,
  output logic signed [vfc_pkg::COORD_W-1:0]  vert_x,
  output logic signed [vfc_pkg::COORD_W-1:0]  vert_y,
  output logic signed [vfc_pkg::COORD_W-1:0]  vert_z,
  output logic [2:0]                          face_dir,
  output logic [1:0]                          corner,
  output logic [vfc_pkg::INDEX_W-1:0]         index_base,
  output logic                                last
);

  import vfc_pkg::*;

  localparam int CELLS = GRID_EDGE * GRID_EDGE * GRID_EDGE;
  localparam int AW = $clog2(CELLS);
  localparam logic [5:0] EDGE_LAST = 6'(GRID_EDGE - 1);
  localparam logic [6:0] EDGE_W = 7'(GRID_EDGE);

  state_t state, state_next;
  logic [2:0] scan, scan_next;
  logic [2:0] cur_face, cur_face_next;
  logic [1:0] cur_corner, cur_corner_next;
  logic [NUM_FACES-1:0] mask, mask_next;
  logic [NUM_FACES-1:0] oob_mask, oob_mask_next;
  logic [COUNT_W-1:0] face_count, face_count_next;
  logic [5:0] cx, cy, cz, cx_next, cy_next, cz_next;
  logic signed [COORD_W-1:0] base_x, base_y, base_z;
  logic signed [COORD_W-1:0] base_x_next, base_y_next, base_z_next;
  logic signed [15:0] origin_x, origin_y, origin_z;

  logic          accept;
  logic          in_grid;
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic          ram_rdata;
  logic          ram_clearing;
  logic [AW-1:0] in_addr, center_addr, nb_addr;
  logic [5:0]    nx, ny, nz;
  logic          nb_oob;
  logic [2:0]    scan_prev;
  logic [NUM_FACES-1:0] rest;
  vtx_cmd_t      vcmd;

  function automatic logic [AW-1:0] cell_addr(input logic [5:0] x,
                                              input logic [5:0] y,
                                              input logic [5:0] z);
    return AW'(32'(x) * GRID_EDGE * GRID_EDGE + 32'(y) * GRID_EDGE + 32'(z));
  endfunction

  function automatic logic signed [COORD_W-1:0] half_base(input logic [15:0] org,
                                                          input logic [5:0] v);
    logic [16:0] s;
    s = {org[15], org} + {11'd0, v};
    return {s, 1'b0};
  endfunction

  assign busy    = ram_clearing || (state != ST_IDLE);
  assign accept  = start && !busy;
  assign in_grid = ({1'b0, voxel_x} < EDGE_W) && ({1'b0, voxel_y} < EDGE_W) &&
                   ({1'b0, voxel_z} < EDGE_W);
  assign in_addr     = cell_addr(voxel_x, voxel_y, voxel_z);
  assign center_addr = cell_addr(cx, cy, cz);
  assign nb_addr     = cell_addr(nx, ny, nz);
  assign scan_prev   = scan - 3'd1;
  assign rest        = mask & ~(NUM_FACES'(1) << cur_face);

  always_comb begin
    nx = cx;
    ny = cy;
    nz = cz;
    nb_oob = 1'b0;
    case (scan)
      FACE_PZ: begin
        nz = cz + 6'd1;
        nb_oob = (cz == EDGE_LAST);
      end
      FACE_PX: begin
        nx = cx + 6'd1;
        nb_oob = (cx == EDGE_LAST);
      end
      FACE_NX: begin
        nx = cx - 6'd1;
        nb_oob = (cx == 6'd0);
      end
      FACE_NZ: begin
        nz = cz - 6'd1;
        nb_oob = (cz == 6'd0);
      end
      FACE_PY: begin
        ny = cy + 6'd1;
        nb_oob = (cy == EDGE_LAST);
      end
      FACE_NY: begin
        ny = cy - 6'd1;
        nb_oob = (cy == 6'd0);
      end
      default: nb_oob = 1'b1;
    endcase
  end

  always_comb begin
    state_next      = state;
    scan_next       = scan;
    cur_face_next   = cur_face;
    cur_corner_next = cur_corner;
    mask_next       = mask;
    oob_mask_next   = oob_mask;
    face_count_next = face_count;
    cx_next         = cx;
    cy_next         = cy;
    cz_next         = cz;
    base_x_next     = base_x;
    base_y_next     = base_y;
    base_z_next     = base_z;
    ram_we          = 1'b0;
    ram_raddr       = center_addr;
    vcmd            = '0;
    unique case (state)
      ST_IDLE: begin
        ram_raddr = in_addr;
        if (accept) begin
          cx_next     = voxel_x;
          cy_next     = voxel_y;
          cz_next     = voxel_z;
          base_x_next = half_base(origin_x, voxel_x);
          base_y_next = half_base(origin_y, voxel_y);
          base_z_next = half_base(origin_z, voxel_z);
          case (req_type)
            REQ_RESTART: face_count_next = '0;
            REQ_WRITE:   ram_we = in_grid;
            REQ_EMIT: begin
              if (in_grid) begin
                state_next = ST_CENTER;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CENTER: begin
        if (ram_rdata) begin
          state_next = ST_SCAN;
          scan_next  = 3'd0;
          mask_next  = '0;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (scan != 3'd6) begin
          ram_raddr = nb_oob ? center_addr : nb_addr;
          oob_mask_next[scan] = nb_oob;
        end
        if (scan != 3'd0) begin
          mask_next[scan_prev] = oob_mask[scan_prev] | ~ram_rdata;
        end
        scan_next = scan + 3'd1;
        if (scan == 3'd6) begin
          if (mask_next == '0) begin
            state_next = ST_IDLE;
          end else begin
            state_next      = ST_EMIT;
            cur_face_next   = first_face(mask_next);
            cur_corner_next = 2'd0;
          end
        end
      end
      ST_EMIT: begin
        vcmd.valid      = 1'b1;
        vcmd.face       = cur_face;
        vcmd.corner     = cur_corner;
        vcmd.index_base = {face_count, 2'b00};
        vcmd.last       = (cur_corner == 2'd3) && (rest == '0);
        cur_corner_next = cur_corner + 2'd1;
        if (cur_corner == 2'd3) begin
          mask_next       = rest;
          face_count_next = face_count + 1'b1;
          if (rest == '0) begin
            state_next = ST_IDLE;
          end else begin
            cur_face_next = first_face(rest);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      scan       <= 3'd0;
      face_count <= '0;
      origin_x   <= '0;
      origin_y   <= '0;
      origin_z   <= '0;
    end else begin
      state      <= state_next;
      scan       <= scan_next;
      face_count <= face_count_next;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_ORIGIN_X: origin_x <= cfg_wdata;
          CFG_ORIGIN_Y: origin_y <= cfg_wdata;
          CFG_ORIGIN_Z: origin_z <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_face   <= cur_face_next;
    cur_corner <= cur_corner_next;
    mask       <= mask_next;
    oob_mask   <= oob_mask_next;
    cx         <= cx_next;
    cy         <= cy_next;
    cz         <= cz_next;
    base_x     <= base_x_next;
    base_y     <= base_y_next;
    base_z     <= base_z_next;
  end

  vfc_occ_ram #(
    .DEPTH(CELLS),
    .AW   (AW)
  ) u_occ (
    .clk     (clk),
    .rst     (rst),
    .we      (ram_we),
    .waddr   (in_addr),
    .wdata   (occupied),
    .raddr   (ram_raddr),
    .rdata   (ram_rdata),
    .clearing(ram_clearing)
  );

  vfc_vtx_gen u_vtx (
    .clk       (clk),
    .rst       (rst),
    .cmd       (vcmd),
    .base_x    (base_x),
    .base_y    (base_y),
    .base_z    (base_z),
    .strobe    (strobe),
    .vert_x    (vert_x),
    .vert_y    (vert_y),
    .vert_z    (vert_z),
    .face_dir  (face_dir),
    .corner    (corner),
    .index_base(index_base),
    .last      (last)
  );

  `VFC_ASSERT_IMP(a_emit_face_exposed, state == ST_EMIT, mask[cur_face])
  `VFC_ASSERT_IMP(a_strobe_after_emit, strobe, $past(state) == ST_EMIT)
  `VFC_ASSERT_IMP(a_last_on_corner3, strobe && last, corner == 2'd3)
  `VFC_ASSERT_NEXT(a_count_step, state == ST_EMIT && cur_corner == 2'd3,
                   face_count == COUNT_W'($past(face_count) + 1'b1))

endmodule
`default_nettype wire
